// File: sv/sui_pkg.sv
// ----------------------------------------------------------------------------
// sui_pkg
// Shared types, codes and the pass table of the set union / intersection /
// difference engine.
// ----------------------------------------------------------------------------
package sui_pkg;

  localparam int SET_DEPTH_DEF = 32;
  localparam int VAL_W         = 32;

  // request codes carried in the input tuser
  typedef enum logic [1:0] {
    REQ_ADD_A = 2'd0,
    REQ_ADD_B = 2'd1,
    REQ_RUN   = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_ELEM   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  // load status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // operation codes
  localparam logic [2:0] OP_UNION = 3'd0;
  localparam logic [2:0] OP_INTER = 3'd1;
  localparam logic [2:0] OP_A_B   = 3'd2;
  localparam logic [2:0] OP_B_A   = 3'd3;
  localparam logic [2:0] OP_SYM   = 3'd4;

  // what a probe does when it leaves the chain
  typedef enum logic [1:0] {
    PK_LOAD  = 2'd0,
    PK_ELEM  = 2'd1,
    PK_END   = 2'd2,
    PK_CLEAR = 2'd3
  } pkind_t;

  typedef struct packed {
    logic             vld;
    pkind_t           kind;
    logic             cmp_b;        // compare against set B, else set A
    logic             keep_in;      // keep the element when it is found
    logic             always_keep;  // keep the element unconditionally
    logic             hit;          // found in the compared set so far
    logic [VAL_W-1:0] val;
  } probe_t;

  typedef struct packed {
    logic en;
    logic src_b;
    logic keep_in;
    logic always_keep;
  } pass_t;

  // source and filter of each pass of a run
  function automatic pass_t pass_desc(input logic [2:0] op, input logic second);
    pass_t d;
    d = '0;
    unique case (op)
      OP_UNION: d = second ? '{1'b1, 1'b1, 1'b0, 1'b0} : '{1'b1, 1'b0, 1'b0, 1'b1};
      OP_INTER: d = second ? '0 : '{1'b1, 1'b0, 1'b1, 1'b0};
      OP_A_B:   d = second ? '0 : '{1'b1, 1'b0, 1'b0, 1'b0};
      OP_B_A:   d = second ? '0 : '{1'b1, 1'b1, 1'b0, 1'b0};
      OP_SYM:   d = second ? '{1'b1, 1'b1, 1'b0, 1'b0} : '{1'b1, 1'b0, 1'b0, 1'b0};
      default:  d = '0;
    endcase
    return d;
  endfunction

endpackage

// File: sv/sui_cell.sv
// ----------------------------------------------------------------------------
// sui_cell
// One slot of the set chain: holds one element of A and one of B, compares
// the passing probe against the selected one and hands the probe on.
// ----------------------------------------------------------------------------
module sui_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              act_a,
  input  logic                              act_b,
  input  logic                              wr_a,
  input  logic                              wr_b,
  input  logic [sui_pkg::VAL_W-1:0]         wr_data,
  input  sui_pkg::probe_t                   probe_in,
  output sui_pkg::probe_t                   probe_out,
  output logic [sui_pkg::VAL_W-1:0]         a_val,
  output logic [sui_pkg::VAL_W-1:0]         b_val
);
  import sui_pkg::*;

  logic [VAL_W-1:0] a_q;
  logic [VAL_W-1:0] b_q;
  probe_t           probe_next;
  logic             match;

  assign a_val = a_q;
  assign b_val = b_q;

  always_comb begin
    match = probe_in.cmp_b ? (act_b && (b_q == probe_in.val))
                           : (act_a && (a_q == probe_in.val));
    probe_next     = probe_in;
    probe_next.hit = probe_in.hit | match;
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_q <= wr_data;
    end
    if (wr_b) begin
      b_q <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else if (adv) begin
      probe_out <= probe_next;
    end
  end

endmodule

// File: sv/set_union_intersect_difference.sv
// ----------------------------------------------------------------------------
// set_union_intersect_difference
// Two small sets of signed 32-bit values held in a chain of compare cells;
// load, clear and run requests stream set operations out.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ------------------------------------------
//  s_*      in   s_tvalid/s_tready  tdata: value; tuser: req_type
//  m_*      out  m_tvalid/m_tready  tdata: out_value, load_status;
//                                   tuser: out_kind; tlast: out_last
//  cfg_*    in   cfg_we             cfg_wdata: op_mode
//
//  A load or clear item sends one probe down the cell chain, one cell per
//  cycle while the output is not stalled; the status is known at the tail.
//  In a run, one probe per source element enters the chain each cycle
//  while the output is not stalled, so the chain length sets the latency
//  and the source sizes set the issue time.
//  A stalled output freezes the whole chain; nothing is dropped.
//  Reset (synchronous) empties both sets and clears op_mode to union.
//
module set_union_intersect_difference #(
  parameter int SET_DEPTH = sui_pkg::SET_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] out_value, [33:32] load_status, zero pad
  output logic [1:0]  m_tuser,   // [1:0] out_kind
  output logic        m_tlast,   // out_last
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata  // op_mode
);
  import sui_pkg::*;

  localparam int CW = $clog2(SET_DEPTH + 1);
  localparam int IW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS1,
    S_PASS2,
    S_END,
    S_DRAIN
  } state_t;

  state_t           state;
  logic [2:0]       op_mode;
  logic [CW-1:0]    count_a;
  logic [CW-1:0]    count_b;
  logic [CW-1:0]    j;
  logic [VAL_W-1:0] held_val;
  logic             have_held;

  probe_t           probes [SET_DEPTH+1];
  logic [VAL_W-1:0] a_vals [SET_DEPTH];
  logic [VAL_W-1:0] b_vals [SET_DEPTH];

  logic             adv;
  pass_t            desc;
  logic [CW-1:0]    src_n;
  logic [VAL_W-1:0] src_val;
  probe_t           ins;
  probe_t           ex;
  logic             ex_fire;
  logic [CW-1:0]    tcnt;

  logic             push;
  logic [VAL_W-1:0] push_val;
  logic [1:0]       push_kind;
  logic [1:0]       push_status;
  logic             push_last;
  logic             wr_a_en;
  logic             wr_b_en;
  logic             do_clear;
  logic             keep;

  // the chain moves whenever the output slot can take a new item
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && adv;

  // source of the current run pass
  always_comb begin
    desc    = pass_desc(op_mode, state == S_PASS2);
    src_n   = desc.src_b ? count_b : count_a;
    src_val = desc.src_b ? b_vals[j[IW-1:0]] : a_vals[j[IW-1:0]];
  end

  // probe entering the head of the chain
  always_comb begin
    ins = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && adv) begin
          unique case (req_t'(s_tuser))
            REQ_ADD_A, REQ_ADD_B: begin
              ins.vld   = 1'b1;
              ins.kind  = PK_LOAD;
              ins.cmp_b = s_tuser[0];
              ins.val   = s_tdata;
            end
            REQ_CLEAR: begin
              ins.vld  = 1'b1;
              ins.kind = PK_CLEAR;
            end
            default: ins = '0;
          endcase
        end
      end
      S_PASS1, S_PASS2: begin
        if (adv && desc.en && (j < src_n)) begin
          ins.vld         = 1'b1;
          ins.kind        = PK_ELEM;
          ins.cmp_b       = !desc.src_b;
          ins.keep_in     = desc.keep_in;
          ins.always_keep = desc.always_keep;
          ins.val         = src_val;
        end
      end
      S_END: begin
        if (adv) begin
          ins.vld  = 1'b1;
          ins.kind = PK_END;
        end
      end
      default: ins = '0;
    endcase
  end

  assign probes[0] = ins;

  for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
    sui_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .act_a     (CW'(i) < count_a),
      .act_b     (CW'(i) < count_b),
      .wr_a      (wr_a_en && (count_a == CW'(i))),
      .wr_b      (wr_b_en && (count_b == CW'(i))),
      .wr_data   (ex.val),
      .probe_in  (probes[i]),
      .probe_out (probes[i+1]),
      .a_val     (a_vals[i]),
      .b_val     (b_vals[i])
    );
  end

  assign ex      = probes[SET_DEPTH];
  assign ex_fire = adv && ex.vld;
  assign tcnt    = ex.cmp_b ? count_b : count_a;

  // resolve the probe leaving the tail of the chain
  always_comb begin
    push        = 1'b0;
    push_val    = '0;
    push_kind   = KIND_STATUS;
    push_status = ST_OK;
    push_last   = 1'b0;
    wr_a_en     = 1'b0;
    wr_b_en     = 1'b0;
    do_clear    = 1'b0;
    keep        = ex.always_keep || (ex.hit == ex.keep_in);
    if (ex_fire) begin
      unique case (ex.kind)
        PK_LOAD: begin
          push      = 1'b1;
          push_last = 1'b1;
          if (ex.hit) begin
            push_status = ST_DUP;
          end else if (tcnt >= CW'(SET_DEPTH)) begin
            push_status = ST_FULL;
          end else begin
            wr_a_en = !ex.cmp_b;
            wr_b_en = ex.cmp_b;
          end
        end
        PK_CLEAR: begin
          push      = 1'b1;
          push_last = 1'b1;
          do_clear  = 1'b1;
        end
        PK_ELEM: begin
          // hold the newest kept element back until the next one shows
          if (keep && have_held) begin
            push      = 1'b1;
            push_val  = held_val;
            push_kind = KIND_ELEM;
          end
        end
        PK_END: begin
          push      = 1'b1;
          push_last = 1'b1;
          if (have_held) begin
            push_val  = held_val;
            push_kind = KIND_ELEM;
          end else begin
            push_kind = KIND_EMPTY;
          end
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op_mode   <= OP_UNION;
      count_a   <= '0;
      count_b   <= '0;
      j         <= '0;
      have_held <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        op_mode <= cfg_wdata;
      end

      // set counts
      if (do_clear) begin
        count_a <= '0;
        count_b <= '0;
      end
      if (wr_a_en) begin
        count_a <= count_a + CW'(1);
      end
      if (wr_b_en) begin
        count_b <= count_b + CW'(1);
      end

      // held element of a run
      if (ex_fire && (ex.kind == PK_ELEM) && keep) begin
        held_val  <= ex.val;
        have_held <= 1'b1;
      end else if (ex_fire && (ex.kind == PK_END)) begin
        have_held <= 1'b0;
      end

      // output register
      if (adv) begin
        m_tvalid <= push;
        m_tdata  <= {6'd0, push_status, push_val};
        m_tuser  <= push_kind;
        m_tlast  <= push_last;
      end

      // sequencer
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            j <= '0;
            if (req_t'(s_tuser) == REQ_RUN) begin
              state <= S_PASS1;
            end else begin
              state <= S_DRAIN;
            end
          end
        end
        S_PASS1, S_PASS2: begin
          if (adv) begin
            if (desc.en && (j < src_n)) begin
              j <= j + CW'(1);
            end else begin
              j     <= '0;
              state <= (state == S_PASS1) ? S_PASS2 : S_END;
            end
          end
        end
        S_END: begin
          if (adv) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (ex_fire && (ex.kind != PK_ELEM)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // counts never pass the set depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count_a <= CW'(SET_DEPTH)) && (count_b <= CW'(SET_DEPTH)))
    else $error("set count beyond depth");

  // a closing probe only leaves the chain while the sequencer waits for it
  a_close_in_drain: assert property (@(posedge clk) disable iff (rst)
    (ex.vld && (ex.kind != PK_ELEM)) |-> (state == S_DRAIN))
    else $error("closing probe outside drain");

  // no element is held back between requests
  a_held_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !have_held)
    else $error("held element while idle");

  // a load grows set A by at most one
  a_load_step: assert property (@(posedge clk) disable iff (rst)
    !$past(do_clear) && !$past(rst) |->
      ((count_a == $past(count_a)) || (count_a == $past(count_a) + CW'(1))))
    else $error("count_a jumped");

endmodule

// File: test/sui_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sui_checker
// Watches the request, result and op_mode channels of the set engine, keeps
// its own copy of both sets, and compares every result item field by field.
// ----------------------------------------------------------------------------
module sui_checker
  import sui_pkg::*;
#(
  parameter int SET_DEPTH = SET_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  output int          fail_count,
  output int          open_results,
  output int          items_seen,
  output int          results_seen,
  output int          elems_seen,
  output int          empty_seen,
  output int          dup_seen,
  output int          full_seen
);

  typedef struct {
    logic [31:0] value;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic        last;
  } set_result_t;

  set_result_t set_result_q[$];

  logic [31:0] a_elems [SET_DEPTH];
  logic [31:0] b_elems [SET_DEPTH];
  int          a_size;
  int          b_size;
  logic [2:0]  op_sel;

  int mismatches;
  int n_items;
  int n_results;
  int n_elems;
  int n_empty;
  int n_dup;
  int n_full;

  function automatic bit in_set(input bit from_b, input logic [31:0] v);
    for (int i = 0; i < (from_b ? b_size : a_size); i++)
      if ((from_b ? b_elems[i] : a_elems[i]) == v) return 1'b1;
    return 1'b0;
  endfunction

  task automatic add_result(input logic [31:0] v, input logic [1:0] kind,
                            input logic [1:0] status);
    set_result_t r;
    r.value  = v;
    r.kind   = kind;
    r.status = status;
    r.last   = 1'b0;
    set_result_q.push_back(r);
  endtask

  // walk one set; keep an element when its membership in the other set
  // matches keep_in, or always when keep_all
  task automatic emit_pass(input bit src_b, input bit keep_in, input bit keep_all);
    logic [31:0] v;
    for (int i = 0; i < (src_b ? b_size : a_size); i++) begin
      v = src_b ? b_elems[i] : a_elems[i];
      if (keep_all || (in_set(!src_b, v) == keep_in)) add_result(v, KIND_ELEM, ST_OK);
    end
  endtask

  // duplicate check against the whole set comes before the full check
  task automatic load_elem(input bit to_b, input logic [31:0] v);
    logic [1:0] st;
    if (in_set(to_b, v)) begin
      st = ST_DUP;
    end else if ((to_b ? b_size : a_size) >= SET_DEPTH) begin
      st = ST_FULL;
    end else begin
      st = ST_OK;
      if (to_b) begin
        b_elems[b_size] = v;
        b_size++;
      end else begin
        a_elems[a_size] = v;
        a_size++;
      end
    end
    add_result('0, KIND_STATUS, st);
  endtask

  task automatic apply_set_request(input req_t req, input logic [31:0] v);
    int          base_n;
    set_result_t tail;
    base_n = set_result_q.size();
    case (req)
      REQ_ADD_A: load_elem(1'b0, v);
      REQ_ADD_B: load_elem(1'b1, v);
      REQ_RUN: begin
        case (op_sel)
          OP_UNION: begin
            emit_pass(1'b0, 1'b0, 1'b1);
            emit_pass(1'b1, 1'b0, 1'b0);
          end
          OP_INTER: emit_pass(1'b0, 1'b1, 1'b0);
          OP_A_B:   emit_pass(1'b0, 1'b0, 1'b0);
          OP_B_A:   emit_pass(1'b1, 1'b0, 1'b0);
          OP_SYM: begin
            emit_pass(1'b0, 1'b0, 1'b0);
            emit_pass(1'b1, 1'b0, 1'b0);
          end
          default: ;
        endcase
        if (set_result_q.size() == base_n) add_result('0, KIND_EMPTY, ST_OK);
      end
      default: begin
        a_size = 0;
        b_size = 0;
        add_result('0, KIND_STATUS, ST_OK);
      end
    endcase
    tail = set_result_q.pop_back();
    tail.last = 1'b1;
    set_result_q.push_back(tail);
    n_items++;
  endtask

  task automatic compare_field(input string fname, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] %s mismatch: expected %h, got %h", $time, fname, want_v, got_v);
    end
  endtask

  task automatic check_result();
    set_result_t want;
    n_results++;
    if (set_result_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] result with nothing pending: tdata %h tuser %h tlast %b",
                 $time, m_tdata, m_tuser, m_tlast);
    end else begin
      want = set_result_q.pop_front();
      if (want.kind == KIND_ELEM) n_elems++;
      if (want.kind == KIND_EMPTY) n_empty++;
      if (want.kind == KIND_STATUS && want.status == ST_DUP) n_dup++;
      if (want.kind == KIND_STATUS && want.status == ST_FULL) n_full++;
      compare_field("out_value", want.value, m_tdata[31:0]);
      compare_field("load_status", want.status, m_tdata[33:32]);
      compare_field("tdata pad", '0, m_tdata[39:34]);
      compare_field("out_kind", want.kind, m_tuser);
      compare_field("out_last", want.last, m_tlast);
    end
  endtask

  initial begin
    mismatches = 0;
    n_items    = 0;
    n_results  = 0;
    n_elems    = 0;
    n_empty    = 0;
    n_dup      = 0;
    n_full     = 0;
    a_size     = 0;
    b_size     = 0;
    op_sel     = OP_UNION;
  end

  // inputs are sampled at the edge; counters go out as nonblocking updates
  always @(posedge clk) begin
    if (rst) begin
      a_size = 0;
      b_size = 0;
      op_sel = OP_UNION;
      set_result_q.delete();
    end else begin
      if (cfg_we) op_sel = cfg_wdata;
      if (s_tvalid && s_tready) apply_set_request(req_t'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) check_result();
    end
    fail_count   <= mismatches;
    open_results <= set_result_q.size();
    items_seen   <= n_items;
    results_seen <= n_results;
    elems_seen   <= n_elems;
    empty_seen   <= n_empty;
    dup_seen     <= n_dup;
    full_seen    <= n_full;
  end

endmodule

// File: test/tb_set_union_intersect_difference.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_union_intersect_difference
// Drives load, clear and run requests into the set engine under several
// op_mode settings and idling patterns; a checker beside the block predicts
// and compares every result item.
// ----------------------------------------------------------------------------
module tb_set_union_intersect_difference
  import sui_pkg::*;
;

  localparam int DEPTH = SET_DEPTH_DEF;

  // op_mode values the block leaves unused; a run under them gives the
  // empty marker
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // pause after the last result before a register write or the verdict:
  // a load walks the whole chain, so the pause is sized from the chain depth
  localparam int SETTLE_CYCLES = DEPTH + 8;

  // timeout: 15 ms of simulated time, several times a worst-case run of ~420 items
  // each causing a full 64-item result under heavy receiver stalls
  localparam longint TIMEOUT_NS = 64'd15_000_000;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = REQ_ADD_A;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_wdata = OP_UNION;

  // receiver idling, shared with the ready process
  int rx_idle_pct = 64;
  bit rx_hold     = 1'b0;

  // sender idling, used only by the stimulus process
  int tx_idle_pct = 13;
  int n_sent      = 0;

  // small pool of values reused across both sets so that overlaps happen
  logic [31:0] shared_vals [8];

  int fail_count;
  int open_results;
  int items_seen;
  int results_seen;
  int elems_seen;
  int empty_seen;
  int dup_seen;
  int full_seen;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  set_union_intersect_difference #(
    .SET_DEPTH (DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),     // [31:0] value
    .s_tuser   (s_tuser),     // [1:0] req_type
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),     // [31:0] out_value, [33:32] load_status, zero pad
    .m_tuser   (m_tuser),     // [1:0] out_kind
    .m_tlast   (m_tlast),     // out_last
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)    // op_mode
  );

  sui_checker #(
    .SET_DEPTH (DEPTH)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .open_results (open_results),
    .items_seen   (items_seen),
    .results_seen (results_seen),
    .elems_seen   (elems_seen),
    .empty_seen   (empty_seen),
    .dup_seen     (dup_seen),
    .full_seen    (full_seen)
  );

  // Receiver: drop ready at random, or hold it low for a whole hold-off
  always @(posedge clk) begin
    if (rx_hold) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one item and hold it until the block takes it. Valid is lowered
  // only in an idle cycle, so back-to-back items keep it high.
  task automatic send_req(input req_t req, input logic [31:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    n_sent++;
  endtask

  // Drop valid and wait until every pending result has come out, then
  // give the block its latency to go quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (open_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write op_mode while the block is idle
  task automatic write_op(input logic [2:0] mode);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic reshuffle_pool();
    for (int i = 0; i < 8; i++)
      shared_vals[i] = ($urandom_range(1) == 0) ? $urandom() : $urandom_range(15);
  endtask

  // Shared values (overlaps, duplicates) as often as random ones, some extremes
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 45) return shared_vals[$urandom_range(7)];
    if (r < 55) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  // Fill one set past its depth, offer a stored value to the full set,
  // optionally fill the other one too, then run.
  task automatic fill_and_run(input bit tgt_b, input bit fill_other);
    req_t        tgt_req;
    req_t        oth_req;
    logic [31:0] first_v;
    tgt_req = tgt_b ? REQ_ADD_B : REQ_ADD_A;
    oth_req = tgt_b ? REQ_ADD_A : REQ_ADD_B;
    send_req(REQ_CLEAR, $urandom());
    first_v = pick_value();
    send_req(tgt_req, first_v);
    repeat (DEPTH + 5)
      send_req(tgt_req, ($urandom_range(3) == 0) ? pick_value() : $urandom());
    // a stored value offered to a full set still answers duplicate
    send_req(tgt_req, first_v);
    if (fill_other) begin
      repeat (DEPTH + 2) send_req(oth_req, $urandom());
    end else begin
      repeat ($urandom_range(6)) send_req(oth_req, pick_value());
    end
    send_req(REQ_RUN, $urandom());
  endtask

  // One random sequence: mostly clear / load / run with random content,
  // some full-set fills, the rest raw noise
  task automatic random_sequence();
    int kind;
    int n_loads;
    kind = $urandom_range(19);
    if (kind < 13) begin
      send_req(REQ_CLEAR, $urandom());
      n_loads = $urandom_range(20);
      repeat (n_loads)
        send_req(($urandom_range(1) == 0) ? REQ_ADD_A : REQ_ADD_B, pick_value());
      repeat ($urandom_range(1, 2)) send_req(REQ_RUN, $urandom());
    end else if (kind < 15) begin
      fill_and_run($urandom_range(1), ($urandom_range(2) == 0));
    end else begin
      repeat ($urandom_range(1, 6)) send_req(req_t'($urandom_range(3)), pick_value());
    end
  endtask

  // Timeout guard
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

  initial begin
    int mode_cursor;
    int target;
    mode_cursor = 0;
    reshuffle_pool();

    // Hold reset, then release once
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---------------- directed part ----------------
    // extremes in set A, a duplicate, overlapping set B, then every op
    send_req(REQ_CLEAR, 32'hFFFF_FFFF);
    send_req(REQ_ADD_A, 32'h8000_0000);
    send_req(REQ_ADD_A, 32'h7FFF_FFFF);
    send_req(REQ_ADD_A, 32'h0000_0000);
    send_req(REQ_ADD_A, 32'hFFFF_FFFF);
    send_req(REQ_ADD_A, 32'h0000_0005);
    send_req(REQ_ADD_A, 32'hFFFF_FFFF);
    send_req(REQ_ADD_B, 32'h0000_0005);
    send_req(REQ_ADD_B, 32'h7FFF_FFFF);
    send_req(REQ_ADD_B, 32'h0000_0007);
    send_req(REQ_ADD_B, 32'h0000_0001);
    send_req(REQ_RUN, 32'h0000_0000);
    // intersection, both differences, symmetric difference, unused mode
    for (int m = OP_INTER; m <= OP_UNUSED_LO; m++) begin
      write_op(3'(m));
      send_req(REQ_RUN, 32'hFFFF_FFFF);
    end
    // run on empty operand sets gives the empty marker
    write_op(OP_INTER);
    send_req(REQ_CLEAR, 32'h0000_0000);
    send_req(REQ_RUN, 32'h0000_0000);

    // ---------------- random part ----------------
    // phase 0: sender idles a little, receiver a lot
    // phase 1: the other way round
    // phase 2: no idling, opened with a long receiver hold-off
    for (int ph = 0; ph < 3; ph++) begin
      settle();
      tx_idle_pct = (ph == 0) ? 13 : ((ph == 1) ? 64 : 0);
      rx_idle_pct <= (ph == 0) ? 64 : ((ph == 1) ? 13 : 0);
      target = n_sent + 100;
      if (ph == 2) begin
        write_op(OP_UNION);
        // keep offering loads while the receiver stalls so the block backs up
        fork
          fill_and_run(1'b0, 1'b0);
          begin
            rx_hold <= 1'b1;
            repeat (600) @(posedge clk);
            rx_hold <= 1'b0;
          end
        join
      end
      while (n_sent < target) begin
        // walk every op_mode in turn, extremes and unused values included
        write_op(3'(mode_cursor % 8));
        mode_cursor++;
        reshuffle_pool();
        repeat (3) random_sequence();
      end
    end
    // finish on the highest code so the last setting is an extreme too
    write_op(OP_UNUSED_HI);
    send_req(REQ_RUN, $urandom());

    // ---------------- drain and verdict ----------------
    settle();
    $display("Covered %0d items over op_mode 0..7 and three idling patterns,",
             items_seen);
    $display("with %0d results: %0d elements, %0d empty markers, %0d dup, %0d full.",
             results_seen, elems_seen, empty_seen, dup_seen, full_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/sui_pkg.sv
sv/sui_cell.sv
sv/set_union_intersect_difference.sv
test/sui_checker.sv
test/tb_set_union_intersect_difference.sv
